// ===== rtl/bm3_pkg.sv =====
package bm3_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 20;
    localparam int COL_W     = 10;
    localparam int ROW_W     = 12;
    localparam int MAX_COLS  = 1024;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 13;
    localparam int CFG_W     = 13;
    localparam int OUT_W     = 40;

    localparam logic [WIDTH_W-1:0]  WIDTH_MIN   = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX   = WIDTH_W'(MAX_COLS);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN  = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = HEIGHT_W'(4096);
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);

    // x / 9 == (x * DIV9_MUL) >> DIV9_SHIFT for x < 2^20
    localparam int               DIV9_SHIFT = 23;
    localparam logic [SUM_W-1:0] DIV9_MUL   = SUM_W'(932068);
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(4);

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic             res;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } tag_t;

    typedef struct packed
    {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
    } lb_ctrl_t;

endpackage

// ===== rtl/bm3_line_buf.sv =====
module bm3_line_buf
(
    input  logic                          clk,
    input  bm3_pkg::lb_ctrl_t             ctrl,
    input  logic [bm3_pkg::SAMPLE_W-1:0]  wr_sample,
    output logic [bm3_pkg::SAMPLE_W-1:0]  top,
    output logic [bm3_pkg::SAMPLE_W-1:0]  mid
);
    import bm3_pkg::*;

    // mem_a: previous row, mem_b: the row before it
    logic [SAMPLE_W-1:0] mem_a [MAX_COLS];
    logic [SAMPLE_W-1:0] mem_b [MAX_COLS];
    logic [SAMPLE_W-1:0] top_reg;
    logic [SAMPLE_W-1:0] mid_reg;

    // consecutive items never share an address while the width is unchanged, so no forwarding path
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            top_reg <= mem_b[ctrl.rd_addr];
            mid_reg <= mem_a[ctrl.rd_addr];
        end
        if (ctrl.wr_en)
        begin
            mem_a[ctrl.wr_addr] <= wr_sample;
            mem_b[ctrl.wr_addr] <= mid_reg;
        end
    end

    assign top = top_reg;
    assign mid = mid_reg;

endmodule

// ===== rtl/bm3_window.sv =====
module bm3_window
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift_en,
    input  logic [bm3_pkg::SAMPLE_W-1:0]  top,
    input  logic [bm3_pkg::SAMPLE_W-1:0]  mid,
    input  logic [bm3_pkg::SAMPLE_W-1:0]  bot,
    output logic [bm3_pkg::SUM_W-1:0]     sum
);
    import bm3_pkg::*;

    // row-major, column 2 newest
    logic [SAMPLE_W-1:0] win_reg [9];
    logic [SUM_W-1:0]    row_sum [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3]   <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= top;
            win_reg[5] <= mid;
            win_reg[8] <= bot;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            row_sum[k] = SUM_W'(win_reg[k*3]) + SUM_W'(win_reg[k*3+1])
                       + SUM_W'(win_reg[k*3+2]);
        end
        sum = row_sum[0] + row_sum[1] + row_sum[2];
    end

endmodule

// ===== rtl/bm3_div9.sv =====
module bm3_div9
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [bm3_pkg::SUM_W-1:0]     sum_in,
    output logic [bm3_pkg::SAMPLE_W-1:0]  mean
);
    import bm3_pkg::*;

    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_rnd;
    logic [2*SUM_W-1:0]  product;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [SAMPLE_W-1:0] mean_next;

    always_comb
    begin
        sum_rnd   = sum_reg + ROUND_HALF;
        product   = (2*SUM_W)'(sum_rnd) * (2*SUM_W)'(DIV9_MUL);
        mean_next = product[DIV9_SHIFT +: SAMPLE_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= sum_in;
            mean_reg <= mean_next;
        end
    end

    assign mean = mean_reg;

endmodule

// ===== rtl/box_mean_3x3.sv =====
// 3x3 box mean over a raster stream of samples
// pipeline: an accepted sample passes the input register, the window register and the divider's sum and mean registers
// throughput: one sample per cycle while the output is not stalled; each line buffer has a separate read and write
// reset: counters, window and control clear at once; width and height return to 1024;
// line buffer contents stay undefined until written
module box_mean_3x3
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  bm3_pkg::cfg_reg_t             cfg_addr,
    input  logic [bm3_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bm3_pkg::SAMPLE_W-1:0]  s_tdata,   // sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bm3_pkg::OUT_W-1:0]     m_tdata,   // mean, out_row, out_col, zero pad
    output logic                          m_tlast
);
    import bm3_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  width_eff;
    logic [HEIGHT_W-1:0] height_eff;
    logic [COL_W-1:0]    col_last;
    logic [ROW_W-1:0]    row_last;

    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic [COL_W-1:0]    col_cur;
    logic [ROW_W-1:0]    row_cur;

    logic                en;
    logic                accept;
    tag_t                tag_new;

    logic                s1_valid_reg;
    logic [COL_W-1:0]    s1_addr_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    tag_t                s1_tag_reg;
    tag_t                s2_tag_reg;
    tag_t                s2_tag_next;
    tag_t                s3_tag_reg;
    tag_t                out_tag_reg;

    lb_ctrl_t            lb_ctrl;
    logic [SAMPLE_W-1:0] lb_top;
    logic [SAMPLE_W-1:0] lb_mid;
    logic [SUM_W-1:0]    win_sum;
    logic [SAMPLE_W-1:0] mean;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[HEIGHT_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        priority if (width_reg < WIDTH_MIN)
            width_eff = WIDTH_MIN;
        else if (width_reg > WIDTH_MAX)
            width_eff = WIDTH_MAX;
        else
            width_eff = width_reg;

        priority if (height_reg < HEIGHT_MIN)
            height_eff = HEIGHT_MIN;
        else if (height_reg > HEIGHT_MAX)
            height_eff = HEIGHT_MAX;
        else
            height_eff = height_reg;

        col_last = COL_W'(width_eff - WIDTH_W'(1));
        row_last = ROW_W'(height_eff - HEIGHT_W'(1));
        col_cur  = (col_reg > col_last) ? col_last : col_reg;
        row_cur  = (row_reg > row_last) ? row_last : row_reg;

        if (col_cur == col_last)
        begin
            col_next = '0;
            row_next = (row_cur == row_last) ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end

        tag_new.res  = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
        tag_new.last = (row_cur == row_last) && (col_cur == col_last);
        tag_new.row  = row_cur - ROW_W'(1);
        tag_new.col  = col_cur - COL_W'(1);
    end

    assign en     = !out_tag_reg.res || m_tready;
    assign accept = s_tvalid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_tag_reg   <= '0;
            s2_tag_reg   <= '0;
            s3_tag_reg   <= '0;
            out_tag_reg  <= '0;
        end
        else if (en)
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= accept;
            s1_tag_reg   <= tag_new;
            s2_tag_reg   <= s2_tag_next;
            s3_tag_reg   <= s2_tag_reg;
            out_tag_reg  <= s3_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg   <= col_cur;
            s1_sample_reg <= s_tdata;
        end
    end

    always_comb
    begin
        s2_tag_next     = s1_tag_reg;
        s2_tag_next.res = s1_valid_reg && s1_tag_reg.res;

        lb_ctrl.rd_en   = accept;
        lb_ctrl.rd_addr = col_cur;
        lb_ctrl.wr_en   = en && s1_valid_reg;
        lb_ctrl.wr_addr = s1_addr_reg;
    end

    bm3_line_buf u_line_buf
    (
        .clk       (clk),
        .ctrl      (lb_ctrl),
        .wr_sample (s1_sample_reg),
        .top       (lb_top),
        .mid       (lb_mid)
    );

    bm3_window u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (lb_ctrl.wr_en),
        .top      (lb_top),
        .mid      (lb_mid),
        .bot      (s1_sample_reg),
        .sum      (win_sum)
    );

    bm3_div9 u_div9
    (
        .clk    (clk),
        .en     (en),
        .sum_in (win_sum),
        .mean   (mean)
    );

    assign s_tready = en;
    assign m_tvalid = out_tag_reg.res;
    assign m_tlast  = out_tag_reg.last;
    assign m_tdata  = {{(OUT_W - SAMPLE_W - ROW_W - COL_W){1'b0}},
                       out_tag_reg.col, out_tag_reg.row, mean};

endmodule

// ===== rtl/bm3_checker.sv =====
module bm3_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [bm3_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          m_tlast
);
    import bm3_pkg::*;

    localparam int ROW_LO = SAMPLE_W;
    localparam int COL_LO = SAMPLE_W + ROW_W;
    localparam int PAD_LO = SAMPLE_W + ROW_W + COL_W;

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // input side never blocks while the output stage is empty
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // only interior positions produce results
    a_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[COL_LO-1:ROW_LO] != '0) && (m_tdata[PAD_LO-1:COL_LO] != '0))
        else $error("result for a border position");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:PAD_LO] == '0)
        else $error("nonzero pad bits in result");

endmodule

bind box_mean_3x3 bm3_checker u_bm3_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/box_mean_3x3_tb.sv =====
`timescale 1ns / 1ps

module box_mean_3x3_tb;

    import bm3_pkg::*;

    localparam int IDLE_PCT    = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RAND_ITEMS  = 520;

    typedef struct {
        logic [SAMPLE_W-1:0] mean;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic                last;
    } box_result_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    cfg_reg_t            cfg_addr  = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OUT_W-1:0]    m_tdata;   // mean, out_row, out_col, zero pad
    logic                m_tlast;

    // predictor state
    bit [SAMPLE_W-1:0] line_a [MAX_COLS];
    bit [SAMPLE_W-1:0] line_b [MAX_COLS];
    bit [SAMPLE_W-1:0] win [9];
    int                col_pos = 0;
    int                row_pos = 0;
    bit [WIDTH_W-1:0]  reg_w   = WIDTH_RESET;
    bit [HEIGHT_W-1:0] reg_h   = HEIGHT_RESET;

    logic [SAMPLE_W-1:0] sample_q [$];
    box_result_t         mean_q [$];

    bit steady = 1'b0;
    int errors = 0;
    int n_in = 0;
    int n_out = 0;
    int n_frames = 0;
    int n_rand = 0;
    int cycles = 0;

    box_mean_3x3 dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int eff_width();
        int w;
        w = reg_w;
        if (w < 3) w = 3;
        if (w > MAX_COLS) w = MAX_COLS;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = reg_h;
        if (h < 3) h = 3;
        if (h > 4096) h = 4096;
        return h;
    endfunction

    // samples still needed to close the current frame
    function automatic int items_to_end();
        int w, h, c, r;
        w = eff_width();
        h = eff_height();
        c = (col_pos > w - 1) ? w - 1 : col_pos;
        r = (row_pos > h - 1) ? h - 1 : row_pos;
        return (h - 1 - r) * w + (w - c);
    endfunction

    task automatic filter_sample(input logic [SAMPLE_W-1:0] s);
        int w, h, c, r, sum;
        bit [SAMPLE_W-1:0] top, mid;
        box_result_t res;
        w = eff_width();
        h = eff_height();
        c = (col_pos > w - 1) ? w - 1 : col_pos;
        r = (row_pos > h - 1) ? h - 1 : row_pos;
        top = line_b[c];
        mid = line_a[c];
        line_b[c] = mid;
        line_a[c] = s;
        for (int k = 0; k < 3; k++)
        begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = s;
        if (r >= 2 && c >= 2)
        begin
            sum = 0;
            for (int k = 0; k < 9; k++)
                sum += win[k];
            res.mean = SAMPLE_W'((sum + 4) / 9);
            res.row  = ROW_W'(r - 1);
            res.col  = COL_W'(c - 1);
            res.last = (r == h - 1 && c == w - 1);
            mean_q.push_back(res);
        end
        if (c >= w - 1)
        begin
            c = 0;
            r = (r >= h - 1) ? 0 : r + 1;
        end
        else
        begin
            c = c + 1;
        end
        col_pos = c;
        row_pos = r;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_W'($urandom_range(0, 15));
            3:       return ~SAMPLE_W'($urandom_range(0, 15));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic int pick_width();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom_range(0, 2);
        if (sel == 1) return $urandom_range(13, 40);
        return $urandom_range(3, 12);
    endfunction

    function automatic int pick_height();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom_range(0, 2);
        if (sel == 1) return $urandom_range(9, 16);
        return $urandom_range(3, 8);
    endfunction

    task automatic feed(input int n);
        for (int i = 0; i < n; i++)
            sample_q.push_back(rand_sample());
        n_rand += n;
    endtask

    // wait until every queued item went in and every mean came out
    task automatic settle();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || s_tvalid || mean_q.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t addr, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= CFG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (addr == REG_IMAGE_WIDTH)
            reg_w = WIDTH_W'(value);
        else
            reg_h = HEIGHT_W'(value);
    endtask

    // sample driver, predictor runs on each accepted item
    always @(posedge clk)
    begin : drive_blk
        if (s_tvalid && s_tready)
        begin
            filter_sample(s_tdata);
            n_in++;
        end
        if (!s_tvalid || s_tready)
        begin
            if (sample_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= sample_q.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : watch_blk
        box_result_t e;
        if (m_tvalid && m_tready)
        begin
            if (mean_q.size() == 0)
            begin
                $error("unexpected result: mean %0d row %0d col %0d",
                       m_tdata[15:0], m_tdata[27:16], m_tdata[37:28]);
                errors++;
            end
            else
            begin
                e = mean_q.pop_front();
                n_out++;
                if (e.last)
                    n_frames++;
                if (m_tdata[15:0] !== e.mean)
                begin
                    $error("mean mismatch: expected %0d, got %0d", e.mean, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[27:16] !== e.row)
                begin
                    $error("out_row mismatch: expected %0d, got %0d", e.row, m_tdata[27:16]);
                    errors++;
                end
                if (m_tdata[37:28] !== e.col)
                begin
                    $error("out_col mismatch: expected %0d, got %0d", e.col, m_tdata[37:28]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last mismatch: expected %0d, got %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stim_blk
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // out-of-range low settings act as a 3x3 frame
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 1);
        repeat (9) sample_q.push_back('1);
        // sum of 4 rounds down, sum of 5 rounds up
        sample_q.push_back(SAMPLE_W'(4));
        repeat (8) sample_q.push_back('0);
        repeat (4) sample_q.push_back('0);
        sample_q.push_back(SAMPLE_W'(5));
        repeat (4) sample_q.push_back('0);
        settle();

        // widest random frame size, no idling on either side
        steady = 1'b1;
        write_reg(REG_IMAGE_WIDTH, 40);
        write_reg(REG_IMAGE_HEIGHT, 4);
        feed(items_to_end());
        settle();
        steady = 1'b0;

        // line buffer entries up to the widest random width are written by
        // now, so a mid-frame width increase never reads an empty entry
        n_rand = 0;
        while (n_rand < RAND_ITEMS)
        begin
            write_reg(REG_IMAGE_WIDTH, pick_width() | ($urandom_range(0, 3) << WIDTH_W));
            write_reg(REG_IMAGE_HEIGHT, pick_height());
            if ($urandom_range(0, 2) == 0)
            begin
                feed($urandom_range(1, items_to_end() - 1));
                settle();
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_IMAGE_HEIGHT, pick_height());
                else
                    write_reg(REG_IMAGE_WIDTH, pick_width());
            end
            k = items_to_end();
            feed(k);
            settle();
        end

        if (mean_q.size() != 0)
        begin
            $error("%0d expected means never arrived", mean_q.size());
            errors++;
        end
        $display("checked %0d means from %0d samples over %0d complete frames",
                 n_out, n_in, n_frames);
        $display("frames from 3x3 up to 40x16, clamped low sizes, mid-frame resizes, stalls");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== box_mean_3x3.f =====
rtl/bm3_pkg.sv
rtl/bm3_line_buf.sv
rtl/bm3_window.sv
rtl/bm3_div9.sv
rtl/box_mean_3x3.sv
rtl/bm3_checker.sv
tb/sv/box_mean_3x3_tb.sv
